### rtl/lpss_pkg.sv
package lpss_pkg;

   // Operation selected by an input transfer
   typedef enum logic [2:0] {
      MODE_ALLOC   = 3'd0,
      MODE_APPEND  = 3'd1,
      MODE_DROP    = 3'd2,
      MODE_FREE    = 3'd3,
      MODE_PLAY    = 3'd4,
      MODE_RESTART = 3'd5,
      MODE_READ    = 3'd6
   } mode_type;

   // Pattern lifecycle codes
   typedef enum logic [1:0] {
      LC_UNUSED = 2'd0,
      LC_USED   = 2'd1,
      LC_DEAD   = 2'd2,
      LC_EMPTY  = 2'd3
   } lc_type;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_POOL  = 2'd1;
   localparam logic [1:0] STAT_BAD   = 2'd2;
   localparam logic [1:0] STAT_BURST = 2'd3;

   // Classified item handed from the front queue to the back sequencer
   typedef struct packed {
      mode_type    mode;
      logic [5:0]  pidx;
      logic [6:0]  sidx;
      logic [31:0] ev;
      logic [15:0] dly;
      logic        pok;
      logic        sok;
   } item_type;

endpackage

### rtl/lpss_ram.sv
module lpss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lpss_front.sv
module lpss_front
   import lpss_pkg::*;
#(
   parameter int STEP_SLOTS    = 128,
   parameter int PATTERN_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,
   output logic        item_valid,
   input  logic        item_take,
   output item_type    item
);

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   incoming;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rptr_ff];

   // Classify the index fields against the pool sizes
   always_comb begin
      incoming.mode = mode_type'(req_tuser);
      incoming.pidx = req_tdata[5:0];
      incoming.sidx = req_tdata[12:6];
      incoming.ev   = req_tdata[44:13];
      incoming.dly  = req_tdata[60:45];
      incoming.pok  = (32'(req_tdata[5:0]) < 32'(PATTERN_SLOTS));
      incoming.sok  = (32'(req_tdata[12:6]) < 32'(STEP_SLOTS));
   end

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = item_take ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= incoming;
      end
   end

endmodule

### rtl/lpss_back.sv
module lpss_back
   import lpss_pkg::*;
#(
   parameter int STEP_SLOTS    = 128,
   parameter int PATTERN_SLOTS = 64,
   parameter int BURST_CAP     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_take,
   input  item_type    item,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int SW  = $clog2(STEP_SLOTS);
   localparam int LW  = $clog2(STEP_SLOTS + 1);
   localparam int PW  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
   localparam int PLW = $clog2(PATTERN_SLOTS + 1);
   localparam int HW  = (LW > PLW) ? LW : PLW;
   localparam int KW  = (BURST_CAP > 1) ? $clog2(BURST_CAP) : 1;
   localparam int CN  = (STEP_SLOTS > PATTERN_SLOTS) ? STEP_SLOTS : PATTERN_SLOTS;
   localparam int CW  = $clog2(CN + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LAST_ACT,
      ST_APP_TIE,
      ST_PLAY_EMIT
   } state_type;

   state_type       state_ff, state_in;
   item_type        cur_ff, cur_in;
   logic [SW-1:0]   last_ff, last_in;
   logic [SW-1:0]   s_ff, s_in;
   logic [SW-1:0]   st_ff, st_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [CW-1:0]   clr_ff, clr_in;
   logic [LW-1:0]   sfree_ff, sfree_in;
   logic [PLW-1:0]  pfree_ff, pfree_in;

   // Step memories share one read address
   logic            st_re;
   logic [SW-1:0]   st_raddr;
   logic            evd_we;
   logic [SW-1:0]   evd_waddr;
   logic [31:0]     ev_rdata;
   logic [15:0]     dly_rdata;
   logic            link_we;
   logic [SW-1:0]   link_waddr;
   logic [LW-1:0]   link_wdata, link_rdata;

   // Pattern memories share one read address
   logic            pt_re;
   logic [PW-1:0]   pt_raddr;
   logic            phead_we;
   logic [PW-1:0]   phead_waddr;
   logic [HW-1:0]   phead_wdata, phead_rdata;
   logic            plast_we;
   logic [SW-1:0]   plast_rdata;
   logic            plc_we;
   logic [PW-1:0]   plc_waddr;
   logic [1:0]      plc_wdata, plc_rdata;

   logic            out_free;
   logic            emit;
   logic [1:0]      o_status;
   logic [6:0]      o_slot;
   logic [31:0]     o_ev;
   logic [15:0]     o_dly;
   logic [6:0]      o_next;
   logic            o_last;

   logic            rsp_valid_ff;
   logic [1:0]      status_ff;
   logic [6:0]      slot_ff;
   logic [31:0]     ev_ff;
   logic [15:0]     dly_ff;
   logic [6:0]      next_ff;
   logic            last_out_ff;

   lc_type          lc;
   logic            cap;
   logic            nx_ok;
   logic            fin;

   lpss_ram #(.WIDTH(32), .DEPTH(STEP_SLOTS)) u_ev (
      .clock, .we(evd_we), .waddr(evd_waddr), .wdata(cur_ff.ev),
      .re(st_re), .raddr(st_raddr), .rdata(ev_rdata));

   lpss_ram #(.WIDTH(16), .DEPTH(STEP_SLOTS)) u_dly (
      .clock, .we(evd_we), .waddr(evd_waddr), .wdata(cur_ff.dly),
      .re(st_re), .raddr(st_raddr), .rdata(dly_rdata));

   lpss_ram #(.WIDTH(LW), .DEPTH(STEP_SLOTS)) u_link (
      .clock, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .re(st_re), .raddr(st_raddr), .rdata(link_rdata));

   lpss_ram #(.WIDTH(HW), .DEPTH(PATTERN_SLOTS)) u_phead (
      .clock, .we(phead_we), .waddr(phead_waddr), .wdata(phead_wdata),
      .re(pt_re), .raddr(pt_raddr), .rdata(phead_rdata));

   lpss_ram #(.WIDTH(SW), .DEPTH(PATTERN_SLOTS)) u_plast (
      .clock, .we(plast_we), .waddr(PW'(cur_ff.pidx)), .wdata(SW'(sfree_ff)),
      .re(pt_re), .raddr(pt_raddr), .rdata(plast_rdata));

   lpss_ram #(.WIDTH(2), .DEPTH(PATTERN_SLOTS)) u_plc (
      .clock, .we(plc_we), .waddr(plc_waddr), .wdata(plc_wdata),
      .re(pt_re), .raddr(pt_raddr), .rdata(plc_rdata));

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign lc       = lc_type'(plc_rdata);
   assign cap      = (32'(k_ff) == 32'(BURST_CAP - 1));
   assign nx_ok    = (32'(link_rdata) < 32'(STEP_SLOTS));
   assign fin      = (dly_rdata != 16'd0) || cap || !nx_ok;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      last_in     = last_ff;
      s_in        = s_ff;
      st_in       = st_ff;
      k_in        = k_ff;
      clr_in      = clr_ff;
      sfree_in    = sfree_ff;
      pfree_in    = pfree_ff;
      item_take   = 1'b0;
      st_re       = 1'b0;
      st_raddr    = st_ff;
      evd_we      = 1'b0;
      evd_waddr   = SW'(sfree_ff);
      link_we     = 1'b0;
      link_waddr  = SW'(sfree_ff);
      link_wdata  = sfree_ff;
      pt_re       = 1'b0;
      pt_raddr    = PW'(cur_ff.pidx);
      phead_we    = 1'b0;
      phead_waddr = PW'(cur_ff.pidx);
      phead_wdata = '0;
      plast_we    = 1'b0;
      plc_we      = 1'b0;
      plc_waddr   = PW'(cur_ff.pidx);
      plc_wdata   = LC_UNUSED;
      emit        = 1'b0;
      o_status    = STAT_OK;
      o_slot      = 7'd0;
      o_ev        = 32'd0;
      o_dly       = 16'd0;
      o_next      = 7'd0;
      o_last      = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            // Rebuild both free lists, one entry a cycle
            link_we     = (32'(clr_ff) < 32'(STEP_SLOTS));
            link_waddr  = SW'(clr_ff);
            link_wdata  = LW'(clr_ff + 1'b1);
            phead_we    = (32'(clr_ff) < 32'(PATTERN_SLOTS));
            phead_waddr = PW'(clr_ff);
            phead_wdata = HW'(clr_ff + 1'b1);
            plc_we      = phead_we;
            plc_waddr   = PW'(clr_ff);
            plc_wdata   = LC_UNUSED;
            clr_in      = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(CN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               cur_in    = item;
               st_re     = 1'b1;
               st_raddr  = (item.mode == MODE_READ) ? SW'(item.sidx) : SW'(sfree_ff);
               pt_re     = 1'b1;
               pt_raddr  = (item.mode == MODE_ALLOC) ? PW'(pfree_ff) : PW'(item.pidx);
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               case (cur_ff.mode)
                  MODE_ALLOC: begin
                     emit = 1'b1;
                     if (32'(pfree_ff) >= 32'(PATTERN_SLOTS)) begin
                        o_status = STAT_POOL;
                     end else begin
                        pfree_in    = PLW'(phead_rdata);
                        phead_we    = 1'b1;
                        phead_waddr = PW'(pfree_ff);
                        phead_wdata = '0;
                        plc_we      = 1'b1;
                        plc_waddr   = PW'(pfree_ff);
                        plc_wdata   = LC_EMPTY;
                        o_slot      = 7'(pfree_ff);
                     end
                  end
                  MODE_APPEND: begin
                     if (!cur_ff.pok || (lc != LC_USED && lc != LC_EMPTY)) begin
                        emit     = 1'b1;
                        o_status = STAT_BAD;
                     end else if (32'(sfree_ff) >= 32'(STEP_SLOTS)) begin
                        emit     = 1'b1;
                        o_status = STAT_POOL;
                     end else begin
                        sfree_in = link_rdata;
                        evd_we   = 1'b1;
                        plast_we = 1'b1;
                        if (lc == LC_EMPTY) begin
                           // First step closes a loop of one
                           link_we     = 1'b1;
                           link_wdata  = sfree_ff;
                           phead_we    = 1'b1;
                           phead_wdata = HW'(sfree_ff);
                           plc_we      = 1'b1;
                           plc_wdata   = LC_USED;
                           emit        = 1'b1;
                           o_slot      = 7'(sfree_ff);
                        end else begin
                           // Fetch the link of the last step to splice in after it
                           s_in     = SW'(sfree_ff);
                           last_in  = plast_rdata;
                           st_re    = 1'b1;
                           st_raddr = plast_rdata;
                           state_in = ST_LAST_ACT;
                        end
                     end
                  end
                  MODE_DROP: begin
                     if (!cur_ff.pok || lc != LC_USED) begin
                        emit     = 1'b1;
                        o_status = STAT_BAD;
                     end else begin
                        phead_we  = 1'b1;
                        plc_we    = 1'b1;
                        plc_wdata = LC_DEAD;
                        last_in   = plast_rdata;
                        st_re     = 1'b1;
                        st_raddr  = plast_rdata;
                        state_in  = ST_LAST_ACT;
                     end
                  end
                  MODE_FREE: begin
                     if (!cur_ff.pok || lc == LC_UNUSED) begin
                        emit     = 1'b1;
                        o_status = STAT_BAD;
                     end else begin
                        phead_we    = 1'b1;
                        phead_wdata = HW'(pfree_ff);
                        pfree_in    = PLW'(cur_ff.pidx);
                        plc_we      = 1'b1;
                        plc_wdata   = LC_UNUSED;
                        if (lc == LC_USED) begin
                           last_in  = plast_rdata;
                           st_re    = 1'b1;
                           st_raddr = plast_rdata;
                           state_in = ST_LAST_ACT;
                        end else begin
                           emit   = 1'b1;
                           o_slot = 7'(cur_ff.pidx);
                        end
                     end
                  end
                  MODE_PLAY: begin
                     if (cur_ff.pok && lc == LC_DEAD) begin
                        phead_we    = 1'b1;
                        phead_wdata = HW'(pfree_ff);
                        pfree_in    = PLW'(cur_ff.pidx);
                        plc_we      = 1'b1;
                        plc_wdata   = LC_UNUSED;
                        emit        = 1'b1;
                        o_status    = STAT_BAD;
                     end else if (!cur_ff.pok || lc != LC_USED) begin
                        emit     = 1'b1;
                        o_status = STAT_BAD;
                     end else begin
                        st_in    = SW'(phead_rdata);
                        st_re    = 1'b1;
                        st_raddr = SW'(phead_rdata);
                        k_in     = '0;
                        state_in = ST_PLAY_EMIT;
                     end
                  end
                  MODE_RESTART: begin
                     if (cur_ff.pok && lc == LC_DEAD) begin
                        phead_we    = 1'b1;
                        phead_wdata = HW'(pfree_ff);
                        pfree_in    = PLW'(cur_ff.pidx);
                        plc_we      = 1'b1;
                        plc_wdata   = LC_UNUSED;
                        emit        = 1'b1;
                        o_slot      = 7'(cur_ff.pidx);
                     end else if (!cur_ff.pok || lc != LC_USED) begin
                        emit     = 1'b1;
                        o_status = STAT_BAD;
                     end else begin
                        st_re    = 1'b1;
                        st_raddr = plast_rdata;
                        state_in = ST_LAST_ACT;
                     end
                  end
                  MODE_READ: begin
                     emit = 1'b1;
                     if (cur_ff.sok) begin
                        o_slot = cur_ff.sidx;
                        o_ev   = ev_rdata;
                        o_dly  = dly_rdata;
                        o_next = 7'(link_rdata);
                     end else begin
                        o_status = STAT_BAD;
                     end
                  end
                  default: begin
                     emit     = 1'b1;
                     o_status = STAT_BAD;
                  end
               endcase
            end
         end
         ST_LAST_ACT: begin
            if (out_free) begin
               state_in = ST_IDLE;
               case (cur_ff.mode)
                  MODE_APPEND: begin
                     link_we    = 1'b1;
                     link_waddr = s_ff;
                     link_wdata = link_rdata;
                     state_in   = ST_APP_TIE;
                  end
                  MODE_DROP, MODE_FREE: begin
                     // Splice the whole loop onto the step free list
                     link_we    = 1'b1;
                     link_waddr = last_ff;
                     link_wdata = sfree_ff;
                     sfree_in   = link_rdata;
                     emit       = 1'b1;
                     o_slot     = 7'(cur_ff.pidx);
                  end
                  MODE_RESTART: begin
                     phead_we    = 1'b1;
                     phead_wdata = HW'(link_rdata);
                     emit        = 1'b1;
                     o_slot      = 7'(cur_ff.pidx);
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_APP_TIE: begin
            if (out_free) begin
               link_we    = 1'b1;
               link_waddr = last_ff;
               link_wdata = LW'(s_ff);
               emit       = 1'b1;
               o_slot     = 7'(s_ff);
               state_in   = ST_IDLE;
            end
         end
         ST_PLAY_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               o_status = (dly_rdata == 16'd0 && cap) ? STAT_BURST : STAT_OK;
               o_slot   = 7'(st_ff);
               o_ev     = ev_rdata;
               o_dly    = dly_rdata;
               o_next   = 7'(link_rdata);
               o_last   = fin;
               if (fin) begin
                  phead_we    = 1'b1;
                  phead_wdata = nx_ok ? HW'(link_rdata) : HW'(st_ff);
                  state_in    = ST_IDLE;
               end else begin
                  st_in    = SW'(link_rdata);
                  st_re    = 1'b1;
                  st_raddr = SW'(link_rdata);
                  k_in     = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sfree_ff     <= '0;
         pfree_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sfree_ff <= sfree_in;
         pfree_ff <= pfree_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cur_ff  <= cur_in;
      last_ff <= last_in;
      s_ff    <= s_in;
      st_ff   <= st_in;
      k_ff    <= k_in;
      if (emit) begin
         status_ff   <= o_status;
         slot_ff     <= o_slot;
         ev_ff       <= o_ev;
         dly_ff      <= o_dly;
         next_ff     <= o_next;
         last_out_ff <= o_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, next_ff, dly_ff, ev_ff, slot_ff};
   assign rsp_tuser  = {(ev_ff[7:0] == 8'hFF), status_ff};
   assign rsp_tlast  = last_out_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result produced while output register is occupied");

   a_sfree_range: assert property (@(posedge clock) disable iff (reset)
      32'(sfree_ff) <= 32'(STEP_SLOTS))
      else $error("step free top out of range");

   a_pfree_range: assert property (@(posedge clock) disable iff (reset)
      32'(pfree_ff) <= 32'(PATTERN_SLOTS))
      else $error("pattern free top out of range");

   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !item_take)
      else $error("item taken during clearing pass");

endmodule

### rtl/looping_pattern_step_store.sv
// An accepted item is registered in the front queue before the sequencer takes it. A table
// operation registers its result from the decode state, or from LAST_ACT (then APP_TIE for an
// append) when a loop link is spliced. Play emits one step a cycle while the result register
// is free, limited by the step memory port. Reset clears control state, then a clearing pass
// rebuilds both free lists; input transfers queue (two deep) but are not processed meanwhile.
module looping_pattern_step_store
   import lpss_pkg::*;
#(
   parameter int STEP_SLOTS    = 128,
   parameter int PATTERN_SLOTS = 64,
   parameter int BURST_CAP     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pattern_index[5:0], step_index[12:6], event_word[44:13], step_delay[60:45], zero fill
   input  logic [63:0] req_tdata,
   // mode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot[6:0], event_out[38:7], delay_out[54:39], next_out[61:55], zero fill
   output logic [63:0] rsp_tdata,
   // status[1:0], internal[2]
   output logic [2:0]  rsp_tuser,
   // last result of the item
   output logic        rsp_tlast
);

   item_type item;
   logic     item_valid;
   logic     item_take;

   // Front: hold accepted transfers and classify their indexes
   lpss_front #(
      .STEP_SLOTS   (STEP_SLOTS),
      .PATTERN_SLOTS(PATTERN_SLOTS)
   ) u_front (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .item_valid,
      .item_take,
      .item
   );

   // Back: walk the step and pattern tables and drive the result register
   lpss_back #(
      .STEP_SLOTS   (STEP_SLOTS),
      .PATTERN_SLOTS(PATTERN_SLOTS),
      .BURST_CAP    (BURST_CAP)
   ) u_back (
      .clock,
      .reset,
      .item_valid,
      .item_take,
      .item,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .rsp_tlast
   );

endmodule
